>>> rtl/core/mctt_pkg.sv
// shared constants and types for the midi clock tempo tracker
// no dependencies
package mctt_pkg;

  localparam int DEF_AVG_DEPTH = 24;

  localparam int BYTE_W      = 8;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int BPM_W       = 26;
  localparam int BPM_STAT_W  = 2;

  localparam logic [BYTE_W-1:0] CLOCK_BYTE      = 8'hF8;
  localparam logic [BYTE_W-1:0] DATA_LIMIT      = 8'h80;
  localparam logic [CNT_W-1:0]  CLOCKS_PER_BEAT = 5'd24;
  localparam longint            BPM_SCALE       = 64'd2500000;
  localparam logic [BPM_W-1:0]  BPM_MAX         = {BPM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CFG_DEFAULT     = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEATS_PER_BAR  = 2'd0,
    CFG_BARS_PER_CYCLE = 2'd1
  } cfg_reg_t;

  typedef enum logic [BPM_STAT_W-1:0] {
    BPM_NONE  = 2'd0,
    BPM_VALID = 2'd1,
    BPM_UNDEF = 2'd2
  } bpm_stat_t;

endpackage

>>> rtl/core/mctt_div.sv
// restoring divider, one quotient bit per cycle
// standalone, no package dependencies
module mctt_div #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 37
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, denom});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= numer;
      end else if (busy_r) begin
        rem_r <= ge ? DEN_W'(trial - {1'b0, denom}) : DEN_W'(trial);
        quo_r <= {quo_r[NUM_W-2:0], ge};
        if (step_r == STEP_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

>>> rtl/core/midi_clock_tempo_tracker_unit.sv
// midi clock tempo tracker top level: period ring, running sum, beat and bar counters
// depends on mctt_pkg and mctt_div
//
// usage: the in_ channel carries one received midi byte with its microsecond
// arrival time; each transfer yields exactly one result on the out_ channel.
// the cfg_ channel writes beats_per_bar (index 0) and bars_per_cycle (index 1)
// and is always ready; write it only while the block is idle.
// one item at a time: in_ready is high only when no item is in flight.
// a non-clock byte goes from idle straight to the output state; a timing clock
// passes through the read and add states first, and the clock that closes the
// ring with a nonzero sum also waits in the divide state for the serial divider,
// which produces one quotient bit per cycle.
// the period ring is a single-port memory, read in the cycle before its write.
// reset clears the ring through per-entry valid bits, so no clearing pass is
// needed and the block is ready as soon as reset is released.
// while the receiver stalls, the result holds on the out_ ports and no new
// input is taken.
module midi_clock_tempo_tracker_unit #(
  parameter int AVG_DEPTH = mctt_pkg::DEF_AVG_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mctt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mctt_pkg::CNT_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mctt_pkg::BYTE_W-1:0]      in_midi_byte,
  input  logic [mctt_pkg::TIME_W-1:0]      in_time_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_is_clock,
  output logic [mctt_pkg::CNT_W-1:0]       out_beat_number,
  output logic [mctt_pkg::CNT_W-1:0]       out_bar_number,
  output logic                             out_beat_start,
  output logic                             out_beat_end,
  output logic [mctt_pkg::BPM_STAT_W-1:0]  out_bpm_status,
  output logic [mctt_pkg::BPM_W-1:0]       out_bpm_value,
  output logic                             out_is_data_byte
);
  import mctt_pkg::*;

  localparam int     IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int     SUM_W = TIME_W + ((AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 0);
  localparam longint NUMER = BPM_SCALE * AVG_DEPTH;
  localparam int     NUM_W = $clog2(NUMER + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ADD,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  bpb_r;
  logic [CNT_W-1:0]  bpc_r;
  logic [TIME_W-1:0] time_r;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] period_r;
  logic [SUM_W-1:0]  sum_r;
  logic [IDX_W-1:0]  ring_idx_r;
  logic [AVG_DEPTH-1:0] ring_vld_r;
  logic              old_vld_r;
  logic [TIME_W-1:0] rd_data_r;
  logic [TIME_W-1:0] ring_mem [AVG_DEPTH];
  logic [CNT_W-1:0]  phase_r;
  logic [CNT_W-1:0]  beat_r;
  logic [CNT_W-1:0]  bar_r;
  logic              is_clock_r;
  logic              bstart_r;
  logic              bend_r;
  bpm_stat_t         status_r;
  logic [BPM_W-1:0]  bpm_r;
  logic              data_r;

  logic              in_xfer;
  logic              ring_we;
  logic [TIME_W-1:0] period_nxt;
  logic [TIME_W-1:0] old_val;
  logic [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]  bpb_eff;
  logic [CNT_W-1:0]  bpc_eff;
  logic [CNT_W:0]    beat_inc;
  logic [CNT_W:0]    bar_inc;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [BPM_W-1:0]  bpm_sat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign ring_we   = (state_r == S_READ);

  assign period_nxt = time_r - last_r;
  assign old_val    = old_vld_r ? rd_data_r : '0;
  assign sum_nxt    = sum_r + SUM_W'(period_r);
  assign bpb_eff    = (bpb_r == '0) ? CNT_W'(1) : bpb_r;
  assign bpc_eff    = (bpc_r == '0) ? CNT_W'(1) : bpc_r;
  assign beat_inc   = {1'b0, beat_r} + 1'b1;
  assign bar_inc    = {1'b0, bar_r} + 1'b1;
  assign div_start  = (state_r == S_ADD) && (ring_idx_r == IDX_W'(AVG_DEPTH - 1)) &&
                      (sum_nxt != '0);
  assign bpm_sat    = (32'(div_quot) > 32'(BPM_MAX)) ? BPM_MAX : BPM_W'(div_quot);

  // sum_r holds the updated sum for the whole division
  mctt_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (NUM_W'(NUMER)),
    .denom (sum_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // period ring storage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data_r <= ring_mem[ring_idx_r];
    end
    if (ring_we) begin
      ring_mem[ring_idx_r] <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpb_r <= CFG_DEFAULT;
      bpc_r <= CFG_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BEATS_PER_BAR) begin
        bpb_r <= cfg_data;
      end else if (cfg_index == CFG_BARS_PER_CYCLE) begin
        bpc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      last_r     <= '0;
      sum_r      <= '0;
      ring_idx_r <= '0;
      ring_vld_r <= '0;
      phase_r    <= '0;
      beat_r     <= '0;
      bar_r      <= CNT_W'(1);
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            time_r     <= in_time_us;
            is_clock_r <= (in_midi_byte == CLOCK_BYTE);
            bstart_r   <= 1'b0;
            bend_r     <= 1'b0;
            status_r   <= BPM_NONE;
            bpm_r      <= '0;
            data_r     <= (in_midi_byte < DATA_LIMIT);
            old_vld_r  <= ring_vld_r[ring_idx_r];
            state_r    <= (in_midi_byte == CLOCK_BYTE) ? S_READ : S_OUT;
          end
        end
        S_READ: begin
          sum_r                  <= sum_r - SUM_W'(old_val);
          period_r               <= period_nxt;
          last_r                 <= time_r;
          ring_vld_r[ring_idx_r] <= 1'b1;
          if (phase_r == '0) begin
            bstart_r <= 1'b1;
            if (beat_inc > {1'b0, bpb_eff}) begin
              beat_r <= CNT_W'(1);
              if (bar_inc > {1'b0, bpc_eff}) begin
                bar_r <= CNT_W'(1);
              end else begin
                bar_r <= CNT_W'(bar_inc);
              end
            end else begin
              beat_r <= CNT_W'(beat_inc);
            end
          end else if (phase_r == CLOCKS_PER_BEAT - 1'b1) begin
            bend_r <= 1'b1;
          end
          phase_r <= (phase_r == CLOCKS_PER_BEAT - 1'b1) ? '0 : phase_r + 1'b1;
          state_r <= S_ADD;
        end
        S_ADD: begin
          sum_r <= sum_nxt;
          if (ring_idx_r == IDX_W'(AVG_DEPTH - 1)) begin
            ring_idx_r <= '0;
            if (sum_nxt != '0) begin
              state_r <= S_DIV;
            end else begin
              status_r <= BPM_UNDEF;
              state_r  <= S_OUT;
            end
          end else begin
            ring_idx_r <= ring_idx_r + 1'b1;
            state_r    <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            status_r <= BPM_VALID;
            bpm_r    <= bpm_sat;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = (state_r == S_OUT);
  assign out_is_clock     = is_clock_r;
  assign out_beat_number  = beat_r;
  assign out_bar_number   = bar_r;
  assign out_beat_start   = bstart_r;
  assign out_beat_end     = bend_r;
  assign out_bpm_status   = status_r;
  assign out_bpm_value    = bpm_r;
  assign out_is_data_byte = data_r;

endmodule

>>> bench/mctt_tempo_checker.sv
`timescale 1ns / 100ps
// result checker for the midi clock tempo tracker: tracks register and byte transfers,
// predicts one result per byte and compares the results in order
// depends on mctt_pkg
module mctt_tempo_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [mctt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mctt_pkg::CNT_W-1:0]       cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [mctt_pkg::BYTE_W-1:0]      in_midi_byte,
  input  logic [mctt_pkg::TIME_W-1:0]      in_time_us,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_is_clock,
  input  logic [mctt_pkg::CNT_W-1:0]       out_beat_number,
  input  logic [mctt_pkg::CNT_W-1:0]       out_bar_number,
  input  logic                             out_beat_start,
  input  logic                             out_beat_end,
  input  logic [mctt_pkg::BPM_STAT_W-1:0]  out_bpm_status,
  input  logic [mctt_pkg::BPM_W-1:0]       out_bpm_value,
  input  logic                             out_is_data_byte,
  output int                               fail_count,
  output int                               pending
);
  import mctt_pkg::*;

  localparam int RING_DEPTH = DEF_AVG_DEPTH;
  localparam logic [63:0] TEMPO_NUM = BPM_SCALE * DEF_AVG_DEPTH;

  typedef struct packed {
    logic             is_clock;
    logic [CNT_W-1:0] beat;
    logic [CNT_W-1:0] bar;
    logic             beat_start;
    logic             beat_end;
    bpm_stat_t        status;
    logic [BPM_W-1:0] bpm;
    logic             data_byte;
  } tempo_result_t;

  logic [TIME_W-1:0] last_clock;
  logic [TIME_W-1:0] period_hist [RING_DEPTH];
  logic [63:0]       period_total;
  int                hist_pos;
  int                clk_phase;
  int                beat_cnt;
  int                bar_cnt;
  int                beats_limit;
  int                bars_limit;
  int                result_no;
  tempo_result_t     tempo_q [$];

  function automatic tempo_result_t track_byte(logic [BYTE_W-1:0] b, logic [TIME_W-1:0] t);
    tempo_result_t r;
    logic [TIME_W-1:0] period;
    logic [63:0] quot;
    int slot;
    r = '0;
    r.status = BPM_NONE;
    if (b == CLOCK_BYTE) begin
      period = t - last_clock;
      r.is_clock = 1'b1;
      last_clock = t;
      slot = hist_pos;
      period_total = period_total - period_hist[slot] + period;
      period_hist[slot] = period;
      slot++;
      if (slot >= RING_DEPTH) begin
        if (period_total != 0) begin
          quot = TEMPO_NUM / period_total;
          r.status = BPM_VALID;
          r.bpm = (quot > BPM_MAX) ? BPM_MAX : quot[BPM_W-1:0];
        end else begin
          r.status = BPM_UNDEF;
        end
        slot = 0;
      end
      hist_pos = slot;
      if (clk_phase == 0) begin
        r.beat_start = 1'b1;
        beat_cnt++;
        if (beat_cnt > ((beats_limit == 0) ? 1 : beats_limit)) begin
          beat_cnt = 1;
          bar_cnt++;
          if (bar_cnt > ((bars_limit == 0) ? 1 : bars_limit))
            bar_cnt = 1;
        end
      end else if (clk_phase == int'(CLOCKS_PER_BEAT) - 1) begin
        r.beat_end = 1'b1;
      end
      clk_phase = (clk_phase + 1) % int'(CLOCKS_PER_BEAT);
    end
    r.beat = CNT_W'(beat_cnt);
    r.bar = CNT_W'(bar_cnt);
    r.data_byte = (b < DATA_LIMIT);
    return r;
  endfunction

  function automatic void log_failure(string why, tempo_result_t got, tempo_result_t want);
    fail_count++;
    if (fail_count <= 10)
      $display("result %0d %s: got clk=%0b beat=%0d bar=%0d start=%0b end=%0b stat=%0d bpm=%0d data=%0b, expected clk=%0b beat=%0d bar=%0d start=%0b end=%0b stat=%0d bpm=%0d data=%0b",
               result_no, why,
               got.is_clock, got.beat, got.bar, got.beat_start, got.beat_end,
               got.status, got.bpm, got.data_byte,
               want.is_clock, want.beat, want.bar, want.beat_start, want.beat_end,
               want.status, want.bpm, want.data_byte);
  endfunction

  always @(posedge clk) begin
    tempo_result_t got;
    tempo_result_t want;
    if (!rst_n) begin
      last_clock = '0;
      for (int i = 0; i < RING_DEPTH; i++)
        period_hist[i] = '0;
      period_total = '0;
      hist_pos = 0;
      clk_phase = 0;
      beat_cnt = 0;
      bar_cnt = 1;
      beats_limit = int'(CFG_DEFAULT);
      bars_limit = int'(CFG_DEFAULT);
      result_no = 0;
      fail_count = 0;
      tempo_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BEATS_PER_BAR: beats_limit = int'(cfg_data);
          CFG_BARS_PER_CYCLE: bars_limit = int'(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.is_clock = out_is_clock;
        got.beat = out_beat_number;
        got.bar = out_bar_number;
        got.beat_start = out_beat_start;
        got.beat_end = out_beat_end;
        got.status = bpm_stat_t'(out_bpm_status);
        got.bpm = out_bpm_value;
        got.data_byte = out_is_data_byte;
        if (tempo_q.size() == 0) begin
          log_failure("with no byte pending", got, '0);
        end else begin
          want = tempo_q.pop_front();
          if (got !== want)
            log_failure("mismatch", got, want);
        end
        result_no++;
      end
      if (in_valid && in_ready)
        tempo_q.push_back(track_byte(in_midi_byte, in_time_us));
    end
    pending <= tempo_q.size();
  end

endmodule

>>> bench/midi_clock_tempo_tracker_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the midi clock tempo tracker: clock, reset, register writes,
// midi byte stimulus with random gaps, result stalls and the final verdict
// depends on mctt_pkg, midi_clock_tempo_tracker_unit and mctt_tempo_checker
module midi_clock_tempo_tracker_unit_tb;
  import mctt_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 85;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_SETTINGS = 6;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BEATS_PER_BAR;
  logic [CNT_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_midi_byte = '0;
  logic [TIME_W-1:0]     in_time_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_is_clock;
  logic [CNT_W-1:0]      out_beat_number;
  logic [CNT_W-1:0]      out_bar_number;
  logic                  out_beat_start;
  logic                  out_beat_end;
  logic [BPM_STAT_W-1:0] out_bpm_status;
  logic [BPM_W-1:0]      out_bpm_value;
  logic                  out_is_data_byte;

  int                    fail_count;
  int                    pending;
  int                    item_count = 0;
  int                    quiet_cycles = 0;
  bit                    steady = 1'b0;
  logic [TIME_W-1:0]     now_us = '0;

  logic [CNT_W-1:0] beat_settings [NUM_SETTINGS] = '{5'd2, 5'd16, 5'd1, 5'd0, 5'd31, 5'd3};
  logic [CNT_W-1:0] bar_settings  [NUM_SETTINGS] = '{5'd2, 5'd16, 5'd1, 5'd0, 5'd31, 5'd1};

  always #6 clk = ~clk;

  midi_clock_tempo_tracker_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_midi_byte     (in_midi_byte),
    .in_time_us       (in_time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_clock     (out_is_clock),
    .out_beat_number  (out_beat_number),
    .out_bar_number   (out_bar_number),
    .out_beat_start   (out_beat_start),
    .out_beat_end     (out_beat_end),
    .out_bpm_status   (out_bpm_status),
    .out_bpm_value    (out_bpm_value),
    .out_is_data_byte (out_is_data_byte)
  );

  mctt_tempo_checker tempo_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_midi_byte     (in_midi_byte),
    .in_time_us       (in_time_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_clock     (out_is_clock),
    .out_beat_number  (out_beat_number),
    .out_bar_number   (out_bar_number),
    .out_beat_start   (out_beat_start),
    .out_beat_end     (out_beat_end),
    .out_bpm_status   (out_bpm_status),
    .out_bpm_value    (out_bpm_value),
    .out_is_data_byte (out_is_data_byte),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] stray_byte();
    logic [BYTE_W-1:0] b;
    b = $urandom_range(0, 255);
    if (b == CLOCK_BYTE)
      b = ~CLOCK_BYTE;
    return b;
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_midi_byte <= b;
    in_time_us <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic clock_run(input int count, input int base_period, input int jitter);
    for (int k = 0; k < count; k++) begin
      // occasional data or status byte between clocks
      if ($urandom_range(0, 9) == 0)
        send_item(stray_byte(), now_us + $urandom_range(0, 200));
      now_us += base_period + $urandom_range(0, jitter);
      send_item(CLOCK_BYTE, now_us);
    end
  endtask

  task automatic run_phase(input int target);
    int roll;
    logic [BYTE_W-1:0] b;
    logic [TIME_W-1:0] t;
    steady = ($urandom_range(0, 3) == 0);
    while (item_count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        clock_run($urandom_range(24, 48), $urandom_range(4000, 60000), $urandom_range(0, 100));
      end else if (roll < 85) begin
        // zero and one microsecond periods, very high or undefined tempo
        clock_run($urandom_range(4, 30), 0, $urandom_range(0, 1));
      end else if (roll < 90) begin
        now_us = $urandom;
      end else begin
        repeat ($urandom_range(1, 6)) begin
          b = $urandom_range(0, 255);
          t = $urandom;
          if (b == CLOCK_BYTE)
            now_us = t;
          send_item(b, t);
        end
      end
    end
  endtask

  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      // one long hold so the block backs up and stalls its input
      if (item_count >= 150 && item_count < 152)
        stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // data byte boundaries and time extremes
    send_item(8'h00, 32'h0000_0000);
    send_item(8'h7F, 32'hFFFF_FFFF);
    send_item(8'h80, 32'h5555_5555);
    send_item(8'hFF, 32'hAAAA_AAAA);
    // first clock measured from time zero, full ring of zero periods gives undefined tempo
    repeat (24) send_item(CLOCK_BYTE, 32'h0000_0000);

    // start close to the time wrap
    now_us = 32'hFFFF_F000;
    run_phase(item_count + PHASE_ITEMS);
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      settle();
      write_reg(CFG_BEATS_PER_BAR, beat_settings[s]);
      write_reg(CFG_BARS_PER_CYCLE, bar_settings[s]);
      run_phase(item_count + PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> midi_clock_tempo_tracker_unit.f
rtl/core/mctt_pkg.sv
rtl/core/mctt_div.sv
rtl/core/midi_clock_tempo_tracker_unit.sv
bench/mctt_tempo_checker.sv
bench/midi_clock_tempo_tracker_unit_tb.sv
